// ----- hdl/nfsm_pkg.sv -----
`default_nettype none

package nfsm_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TRIG_BITS_DEF   = 16;

  localparam int INC_BITS     = 32;
  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic signed [ANGLE_BITS-1:0] CORDIC_X0 = 32'sd652032875;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic signed [ANGLE_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5
  };

endpackage

`default_nettype wire

// ----- hdl/nfsm_front.sv -----
`default_nettype none

module nfsm_front
  import nfsm_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  phase_increment_we_i,
  input  wire logic [INC_BITS-1:0]   phase_increment_i,
  input  wire logic                  accept_i,
  input  wire logic                  block_start_i,
  output logic      [ANGLE_BITS-1:0] z_o,
  output logic                       flip_o
);

  localparam logic signed [ANGLE_BITS-1:0] QUARTER = 32'sh4000_0000;

  logic [INC_BITS-1:0]   inc_q;
  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [PHASE_BITS-1:0] inc_ext;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [ANGLE_BITS-1:0] p32;

  assign inc_ext   = PHASE_BITS'($signed(inc_q));
  assign phase_cur = block_start_i ? '0 : acc_q;
  assign acc_d     = phase_cur + inc_ext;

  // top 32 bits of the phase as a fraction of a turn
  if (PHASE_BITS >= ANGLE_BITS) begin : g_wide
    assign p32 = phase_cur[PHASE_BITS-1 -: ANGLE_BITS];
  end else begin : g_narrow
    assign p32 = {phase_cur, {(ANGLE_BITS-PHASE_BITS){1'b0}}};
  end

  // fold the left half plane onto the right, negate the result later
  assign flip_o = ($signed(p32) > QUARTER) || ($signed(p32) < -QUARTER);
  assign z_o    = flip_o ? {~p32[ANGLE_BITS-1], p32[ANGLE_BITS-2:0]} : p32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q <= '0;
      acc_q <= '0;
    end else begin
      if (phase_increment_we_i) begin
        inc_q <= phase_increment_i;
      end
      if (accept_i) begin
        acc_q <= acc_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_block_start_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && block_start_i && !phase_increment_we_i |=> acc_q == $past(inc_ext))
    else $error("phase not restarted on block start");
`endif

endmodule

`default_nettype wire

// ----- hdl/nfsm_queue.sv -----
`default_nettype none

module nfsm_queue
  import nfsm_pkg::*;
#(
  parameter int DATA_W = 1,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              pop_i,
  output logic      [DATA_W-1:0] data_o,
  output logic                   not_full_o,
  output logic                   not_empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [CW-1:0]     count_q;

  assign not_full_o  = count_q != CW'(DEPTH);
  assign not_empty_o = count_q != '0;
  assign data_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !not_full_o |-> !push_i)
    else $error("push into full queue");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !not_empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_count_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CW'(1))
    else $error("queue count lost a transfer");
`endif

endmodule

`default_nettype wire

// ----- hdl/nfsm_cordic.sv -----
`default_nettype none

module nfsm_cordic
  import nfsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TRIG_BITS   = TRIG_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic        [ANGLE_BITS-1:0]  z_i,
  input  wire logic                          flip_i,
  input  wire logic signed [SAMPLE_BITS-1:0] si_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sq_i,
  output logic                               valid_o,
  output logic signed [TRIG_BITS:0]          cos_o,
  output logic signed [TRIG_BITS:0]          sin_o,
  output logic signed [SAMPLE_BITS-1:0]      si_o,
  output logic signed [SAMPLE_BITS-1:0]      sq_o
);

  localparam int N  = CORDIC_STEPS;
  localparam int TW = TRIG_BITS + 1;
  localparam int SH = ANGLE_BITS - TRIG_BITS;
  localparam logic signed [ANGLE_BITS:0] RND    = (ANGLE_BITS+1)'(1) <<< (SH - 1);
  localparam logic signed [ANGLE_BITS:0] LIM_HI = (ANGLE_BITS+1)'(2**(TRIG_BITS-1) - 1);
  localparam logic signed [ANGLE_BITS:0] LIM_LO = (ANGLE_BITS+1)'(-(2**(TRIG_BITS-1)));

  logic                          vld_q  [N+2];
  logic signed [ANGLE_BITS-1:0]  x_q    [N+1];
  logic signed [ANGLE_BITS-1:0]  y_q    [N+1];
  logic signed [ANGLE_BITS-1:0]  z_q    [N+1];
  logic                          flip_q [N+1];
  logic signed [SAMPLE_BITS-1:0] si_q   [N+2];
  logic signed [SAMPLE_BITS-1:0] sq_q   [N+2];
  logic signed [TW-1:0]          cos_q, sin_q;

  function automatic logic signed [TW-1:0] trig_round(
    input logic signed [ANGLE_BITS-1:0] v,
    input logic                         neg
  );
    logic signed [ANGLE_BITS:0] s;
    logic signed [ANGLE_BITS:0] c;
    logic signed [TW-1:0]       t;
    s = ($signed({v[ANGLE_BITS-1], v}) + RND) >>> SH;
    if (s > LIM_HI) begin
      c = LIM_HI;
    end else if (s < LIM_LO) begin
      c = LIM_LO;
    end else begin
      c = s;
    end
    t = TW'(c);
    return neg ? -t : t;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= $signed(z_i);
      flip_q[0] <= flip_i;
      si_q[0]   <= si_i;
      sq_q[0]   <= sq_i;
      for (int i = 0; i < N; i++) begin
        if (!z_q[i][ANGLE_BITS-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TURNS[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TURNS[i];
        end
        flip_q[i+1] <= flip_q[i];
        si_q[i+1]   <= si_q[i];
        sq_q[i+1]   <= sq_q[i];
      end
      cos_q    <= trig_round(x_q[N], flip_q[N]);
      sin_q    <= trig_round(y_q[N], flip_q[N]);
      si_q[N+1] <= si_q[N];
      sq_q[N+1] <= sq_q[N];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N + 2; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 0; i < N + 1; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  assign valid_o = vld_q[N+1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign si_o    = si_q[N+1];
  assign sq_o    = sq_q[N+1];

endmodule

`default_nettype wire

// ----- hdl/nfsm_mix.sv -----
`default_nettype none

module nfsm_mix
  import nfsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TRIG_BITS   = TRIG_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               en_o,
  input  wire logic                          valid_i,
  input  wire logic signed [TRIG_BITS:0]     cos_i,
  input  wire logic signed [TRIG_BITS:0]     sin_i,
  input  wire logic signed [SAMPLE_BITS-1:0] si_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sq_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [SAMPLE_BITS:0]        out_i_o,
  output logic signed [SAMPLE_BITS:0]        out_q_o
);

  localparam int TW   = TRIG_BITS + 1;
  localparam int PW   = SAMPLE_BITS + TW;
  localparam int SUMW = PW + 1;
  localparam int OW   = SAMPLE_BITS + 1;
  localparam int FR   = TRIG_BITS - 2;
  localparam logic signed [SUMW-1:0] RND = SUMW'(1) <<< (FR - 1);
  localparam logic signed [SUMW-1:0] OHI = SUMW'(2**SAMPLE_BITS - 1);
  localparam logic signed [SUMW-1:0] OLO = SUMW'(-(2**SAMPLE_BITS));

  logic                   vp_q, vs_q, out_valid_q;
  logic signed [PW-1:0]   p_ic_q, p_qs_q, p_is_q, p_qc_q;
  logic signed [SUMW-1:0] s_i_q, s_q_q;
  logic signed [OW-1:0]   out_i_q, out_q_q;

  function automatic logic signed [OW-1:0] finish(input logic signed [SUMW-1:0] p);
    logic signed [SUMW-1:0] r;
    logic signed [SUMW-1:0] c;
    r = (p + RND) >>> FR;
    if (r > OHI) begin
      c = OHI;
    end else if (r < OLO) begin
      c = OLO;
    end else begin
      c = r;
    end
    return OW'(c);
  endfunction

  assign en_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      p_ic_q  <= si_i * cos_i;
      p_qs_q  <= sq_i * sin_i;
      p_is_q  <= si_i * sin_i;
      p_qc_q  <= sq_i * cos_i;
      s_i_q   <= SUMW'(p_ic_q) - SUMW'(p_qs_q);
      s_q_q   <= SUMW'(p_is_q) + SUMW'(p_qc_q);
      out_i_q <= finish(s_i_q);
      out_q_q <= finish(s_q_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      vs_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      vp_q        <= valid_i;
      vs_q        <= vp_q;
      out_valid_q <= vs_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

`ifndef NO_ASSERTIONS
  a_out_follows_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_o |=> out_valid_o == $past(vs_q))
    else $error("output valid out of step with the pipeline");
  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_o |=> $stable(vp_q) && $stable(vs_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

// ----- hdl/nco_frequency_shift_mixer.sv -----
// complex frequency shifter: each sample (I, Q) is rotated by the running
// phase of an nco whose phase advances by phase_increment per transfer
// input channel: in_valid_i / in_ready_o with sample_i_i, sample_q_i and
// block_start_i; block_start_i restarts the phase at zero for that sample
// output channel: out_valid_o / out_ready_i with out_i_o and out_q_o,
// one result per input, in order
// configuration: phase_increment_i is written whenever phase_increment_we_i
// is high; write it only while no transfer is in flight
// throughput: one transfer per cycle, both in and out
// latency: 33 cycles from input transfer to out_valid_o with no stall:
// one cycle in the input queue, 28 cordic stages, one rounding stage,
// a multiply stage, an add stage and the output register
// while a result waits with out_ready_i low the whole back pipeline holds;
// the 4-entry queue keeps taking input until it is full, then in_ready_o drops
// reset clears the phase, the increment, the queue and all valid bits
`default_nettype none

module nco_frequency_shift_mixer
  import nfsm_pkg::*;
#(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TRIG_BITS   = TRIG_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          phase_increment_we_i,
  input  wire logic [INC_BITS-1:0]           phase_increment_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_q_i,
  input  wire logic                          block_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS:0]        out_i_o,
  output logic signed [SAMPLE_BITS:0]        out_q_o
);

  localparam int QW = ANGLE_BITS + 1 + 2 * SAMPLE_BITS;

  logic                          push, pop, not_empty, en;
  logic [ANGLE_BITS-1:0]         front_z, q_z;
  logic                          front_flip, q_flip;
  logic [QW-1:0]                 q_wdata, q_rdata;
  logic signed [SAMPLE_BITS-1:0] q_si, q_sq;
  logic                          c_valid;
  logic signed [TRIG_BITS:0]     c_cos, c_sin;
  logic signed [SAMPLE_BITS-1:0] c_si, c_sq;

  assign push    = in_valid_i && in_ready_o;
  assign pop     = en && not_empty;
  assign q_wdata = {front_z, front_flip, sample_i_i, sample_q_i};
  assign {q_z, q_flip, q_si, q_sq} = q_rdata;

  nfsm_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .phase_increment_we_i,
    .phase_increment_i,
    .accept_i     (push),
    .block_start_i,
    .z_o          (front_z),
    .flip_o       (front_flip)
  );

  nfsm_queue #(
    .DATA_W(QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .data_i     (q_wdata),
    .pop_i      (pop),
    .data_o     (q_rdata),
    .not_full_o (in_ready_o),
    .not_empty_o(not_empty)
  );

  nfsm_cordic #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_cordic (
    .clk_i,
    .rst_ni,
    .en_i   (en),
    .valid_i(not_empty),
    .z_i    (q_z),
    .flip_i (q_flip),
    .si_i   (q_si),
    .sq_i   (q_sq),
    .valid_o(c_valid),
    .cos_o  (c_cos),
    .sin_o  (c_sin),
    .si_o   (c_si),
    .sq_o   (c_sq)
  );

  nfsm_mix #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_mix (
    .clk_i,
    .rst_ni,
    .en_o       (en),
    .valid_i    (c_valid),
    .cos_i      (c_cos),
    .sin_i      (c_sin),
    .si_i       (c_si),
    .sq_i       (c_sq),
    .out_ready_i,
    .out_valid_o,
    .out_i_o,
    .out_q_o
  );

endmodule

`default_nettype wire

// ----- test/nco_frequency_shift_mixer_tb.sv -----
`default_nettype none

module nco_frequency_shift_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = nfsm_pkg::SAMPLE_BITS_DEF;
  localparam int IW = nfsm_pkg::INC_BITS;
  localparam int ROTATOR_STEPS = 28;
  localparam longint ROTATOR_X0 = 64'd652032875;
  localparam longint QUARTER_TURN = 64'h4000_0000;
  localparam longint HALF_TURN = 64'h8000_0000;
  localparam int PIPE_LATENCY = 33;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 56;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_STEP [ROTATOR_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct {
    logic signed [SW:0] re;
    logic signed [SW:0] im;
  } rotated_t;

  class mix_scoreboard;
    logic [IW-1:0] phase_acc;
    logic [IW-1:0] phase_inc;
    rotated_t rotated_q[$];
    int errors;

    function new();
      phase_acc = '0;
      phase_inc = '0;
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function rotated_t rotate(logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                              logic [IW-1:0] angle);
      longint x, y, z, dx, dy, c, s, p_re, p_im;
      bit flip;
      rotated_t r;
      z = longint'($signed(angle));
      x = ROTATOR_X0;
      y = 0;
      flip = 0;
      if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
        flip = 1;
        z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
      end
      for (int i = 0; i < ROTATOR_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP[i];
        end
      end
      c = clamp((x + 64'sd32768) >>> 16, -64'sd32768, 64'sd32767);
      s = clamp((y + 64'sd32768) >>> 16, -64'sd32768, 64'sd32767);
      if (flip) begin
        c = -c;
        s = -s;
      end
      p_re = longint'(si) * c - longint'(sq) * s;
      p_im = longint'(si) * s + longint'(sq) * c;
      r.re = (SW+1)'(clamp((p_re + 64'sd8192) >>> 14, -64'sd65536, 64'sd65535));
      r.im = (SW+1)'(clamp((p_im + 64'sd8192) >>> 14, -64'sd65536, 64'sd65535));
      return r;
    endfunction

    function void set_step(logic [IW-1:0] v);
      phase_inc = v;
    endfunction

    function void note_sample(logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                              logic restart);
      if (restart) phase_acc = '0;
      rotated_q.push_back(rotate(si, sq, phase_acc));
      phase_acc = phase_acc + phase_inc;
    endfunction

    function void check_result(logic signed [SW:0] oi, logic signed [SW:0] oq);
      rotated_t want;
      if (rotated_q.size() == 0) begin
        $error("unexpected output transfer: out_i %0d out_q %0d", oi, oq);
        errors++;
        return;
      end
      want = rotated_q.pop_front();
      if (oi !== want.re) begin
        $error("out_i mismatch: expected %0d, got %0d", want.re, oi);
        errors++;
      end
      if (oq !== want.im) begin
        $error("out_q mismatch: expected %0d, got %0d", want.im, oq);
        errors++;
      end
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic phase_increment_we_i;
  logic [IW-1:0] phase_increment_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [SW-1:0] sample_i_i;
  logic signed [SW-1:0] sample_q_i;
  logic block_start_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [SW:0] out_i_o;
  logic signed [SW:0] out_q_o;

  mix_scoreboard sb;
  bit no_gaps;
  int idle_cycles = 0;

  nco_frequency_shift_mixer DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .phase_increment_we_i (phase_increment_we_i),
    .phase_increment_i    (phase_increment_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .sample_i_i           (sample_i_i),
    .sample_q_i           (sample_q_i),
    .block_start_i        (block_start_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_i_o              (out_i_o),
    .out_q_o              (out_q_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (phase_increment_we_i) sb.set_step(phase_increment_i);
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i_i, sample_q_i, block_start_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_i_o, out_q_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("nco_frequency_shift_mixer_tb failed");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_sample(logic [SW-1:0] si, logic [SW-1:0] sq, logic restart);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i_i <= si;
    sample_q_i <= sq;
    block_start_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_step(logic [IW-1:0] v);
    @(negedge clk_i);
    phase_increment_we_i <= 1'b1;
    phase_increment_i <= v;
    @(negedge clk_i);
    phase_increment_we_i <= 1'b0;
  endtask

  function automatic logic [SW-1:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    logic [IW-1:0] steps [8];
    sb = new();
    rst_ni = 1'b0;
    phase_increment_we_i = 1'b0;
    phase_increment_i = '0;
    in_valid_i = 1'b0;
    sample_i_i = '0;
    sample_q_i = '0;
    block_start_i = 1'b0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero increment after reset: samples pass through
    send_sample(16'h7fff, 16'h7fff, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h7fff, 1'b0);
    send_sample(16'h7fff, 16'h8000, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0001, 16'hffff, 1'b1);
    drain();

    // quarter turns, including the half-turn boundary and the wrap
    write_step(32'h4000_0000);
    send_sample(16'h7fff, 16'h0000, 1'b1);
    send_sample(16'h7fff, 16'h0000, 1'b0);
    send_sample(16'h7fff, 16'h0000, 1'b0);
    send_sample(16'h7fff, 16'h0000, 1'b0);
    send_sample(16'h8000, 16'h8000, 1'b0);
    drain();

    // eighth turns with full-scale corners
    write_step(32'h2000_0000);
    for (int i = 0; i < 9; i++) begin
      send_sample(i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'h8000 : 16'h7fff, i == 0);
    end
    drain();

    steps[0] = 32'h7fff_ffff;
    steps[1] = 32'h8000_0000;
    steps[2] = 32'h0000_0001;
    steps[3] = 32'hffff_ffff;
    steps[4] = $urandom;
    steps[5] = $urandom;
    steps[6] = $urandom_range(0, 65535);
    steps[7] = 32'h0000_0000;
    for (int p = 0; p < 8; p++) begin
      write_step(steps[p]);
      no_gaps = (p % 3 == 2);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_sample(pick_component(), pick_component(), $urandom_range(0, 15) == 0);
      end
      drain();
      no_gaps = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("nco_frequency_shift_mixer_tb passed");
    end else begin
      $display("nco_frequency_shift_mixer_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/nfsm_pkg.sv
hdl/nfsm_front.sv
hdl/nfsm_queue.sv
hdl/nfsm_cordic.sv
hdl/nfsm_mix.sv
hdl/nco_frequency_shift_mixer.sv
test/nco_frequency_shift_mixer_tb.sv
